// ----- rtl/jsu_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the JSON string unescaper.
// Depends on nothing; used by every module of the block.

package jsu_pkg;

  localparam int LEN_W     = 20;
  localparam int JOB_DEPTH = 4;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SYNTAX  = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;
  localparam logic [1:0] ERR_ESCAPE  = 2'd3;

  // Characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CTRL_LIM  = 8'h20;

  localparam logic [7:0] BS_CODE   = 8'h08;
  localparam logic [7:0] FF_CODE   = 8'h0C;
  localparam logic [7:0] LF_CODE   = 8'h0A;
  localparam logic [7:0] CR_CODE   = 8'h0D;
  localparam logic [7:0] TAB_CODE  = 8'h09;

  // Surrogate ranges and code point limits
  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [20:0] CP_1B_LIM   = 21'h80;
  localparam logic [20:0] CP_2B_LIM   = 21'h800;
  localparam logic [20:0] CP_3B_LIM   = 21'h10000;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_STR     = 4'd1,
    M_ESC     = 4'd2,
    M_HEX1    = 4'd3,
    M_NEED_BS = 4'd4,
    M_NEED_U  = 4'd5,
    M_HEX2    = 4'd6,
    M_DRAIN   = 4'd7
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       input_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [7:0]       out_byte;
    logic [1:0]       error_code;
    logic [LEN_W-1:0] decoded_length;
    logic             last;
  } out_item_t;

  // All results caused by one input item
  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       nbytes_m1;
    logic [3:0][7:0]  bytes;
    logic [1:0]       error_code;
    logic [LEN_W-1:0] length;
  } job_t;

  typedef struct packed {
    logic [1:0]      nbytes_m1;
    logic [3:0][7:0] bytes;
  } utf8_t;

  // {valid, value} of an ASCII hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // UTF-8 encoding; byte 0 goes out first
  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp < CP_1B_LIM) begin
      r.nbytes_m1 = 2'd0;
      r.bytes[0]  = {1'b0, cp[6:0]};
    end else if (cp < CP_2B_LIM) begin
      r.nbytes_m1 = 2'd1;
      r.bytes[0]  = {3'b110, cp[10:6]};
      r.bytes[1]  = {2'b10, cp[5:0]};
    end else if (cp < CP_3B_LIM) begin
      r.nbytes_m1 = 2'd2;
      r.bytes[0]  = {4'b1110, cp[15:12]};
      r.bytes[1]  = {2'b10, cp[11:6]};
      r.bytes[2]  = {2'b10, cp[5:0]};
    end else begin
      r.nbytes_m1 = 2'd3;
      r.bytes[0]  = {5'b11110, cp[20:18]};
      r.bytes[1]  = {2'b10, cp[17:12]};
      r.bytes[2]  = {2'b10, cp[11:6]};
      r.bytes[3]  = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// ----- rtl/jsu_front.sv -----
`timescale 1ns / 1ps
// Front end: decode state machine, one raw byte per cycle while in_accept is high;
// builds at most one job per item. Depends on jsu_pkg.

module jsu_front #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_accept,
  input  jsu_pkg::in_item_t in_item,
  output logic             job_push,
  output jsu_pkg::job_t    job
);

  jsu_pkg::mode_t           mode_r, mode_nxt;
  logic [1:0]               hex_cnt_r, hex_cnt_nxt;
  logic [15:0]              hex_acc_r, hex_acc_nxt;
  logic [9:0]               hi_bits_r, hi_bits_nxt;
  logic [COUNT_WIDTH-1:0]   count_r, count_nxt;

  logic [7:0]  c;
  logic [4:0]  hv;
  logic [15:0] acc_new;
  logic        hex_last, is_hi, is_lo;

  // events from the decoder
  logic [1:0]  fail_err;
  logic        done_ev, lit_ev, cp_ev, start_hex, digit_ev, set_hi, clr_cnt;
  logic [7:0]  lit_byte;
  logic [20:0] cp;

  jsu_pkg::utf8_t           enc;
  logic [2:0]               emit_n;
  logic [COUNT_WIDTH:0]     sum;
  logic [COUNT_WIDTH-1:0]   sat;
  logic [COUNT_WIDTH-1:0]   rep_cnt;
  logic [COUNT_WIDTH+jsu_pkg::LEN_W-1:0] rep_wide;

  assign c        = in_item.data_byte;
  assign hv       = jsu_pkg::hex_value(c);
  assign acc_new  = {hex_acc_r[11:0], hv[3:0]};
  assign hex_last = (hex_cnt_r == 2'd3);
  assign is_hi    = (acc_new >= jsu_pkg::HI_SURR_MIN) && (acc_new <= jsu_pkg::HI_SURR_MAX);
  assign is_lo    = (acc_new >= jsu_pkg::LO_SURR_MIN) && (acc_new <= jsu_pkg::LO_SURR_MAX);

  // next state and decode events
  always_comb begin
    mode_nxt  = mode_r;
    fail_err  = jsu_pkg::ERR_NONE;
    done_ev   = 1'b0;
    lit_ev    = 1'b0;
    lit_byte  = c;
    cp_ev     = 1'b0;
    cp        = 21'd0;
    start_hex = 1'b0;
    digit_ev  = 1'b0;
    set_hi    = 1'b0;
    clr_cnt   = 1'b0;
    if (in_item.input_end) begin
      case (mode_r)
        jsu_pkg::M_STR, jsu_pkg::M_ESC: begin
          fail_err = jsu_pkg::ERR_UNTERM;
          mode_nxt = jsu_pkg::M_IDLE;
        end
        jsu_pkg::M_HEX1, jsu_pkg::M_NEED_BS, jsu_pkg::M_NEED_U, jsu_pkg::M_HEX2: begin
          fail_err = jsu_pkg::ERR_ESCAPE;
          mode_nxt = jsu_pkg::M_IDLE;
        end
        default: begin
          mode_nxt = jsu_pkg::M_IDLE;
          clr_cnt  = 1'b1;
        end
      endcase
    end else begin
      case (mode_r)
        jsu_pkg::M_IDLE: begin
          clr_cnt = 1'b1;
          if (c == jsu_pkg::CH_QUOTE) begin
            mode_nxt = jsu_pkg::M_STR;
          end else begin
            fail_err = jsu_pkg::ERR_SYNTAX;
            mode_nxt = jsu_pkg::M_DRAIN;
          end
        end
        jsu_pkg::M_STR: begin
          if (c == jsu_pkg::CH_QUOTE) begin
            done_ev  = 1'b1;
            mode_nxt = jsu_pkg::M_IDLE;
          end else if (c == jsu_pkg::CH_BSLASH) begin
            mode_nxt = jsu_pkg::M_ESC;
          end else if (c < jsu_pkg::CTRL_LIM) begin
            fail_err = jsu_pkg::ERR_SYNTAX;
            mode_nxt = jsu_pkg::M_DRAIN;
          end else begin
            lit_ev = 1'b1;
          end
        end
        jsu_pkg::M_ESC: begin
          mode_nxt = jsu_pkg::M_STR;
          case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: lit_ev = 1'b1;
            jsu_pkg::CH_B: begin
              lit_ev = 1'b1; lit_byte = jsu_pkg::BS_CODE;
            end
            jsu_pkg::CH_F: begin
              lit_ev = 1'b1; lit_byte = jsu_pkg::FF_CODE;
            end
            jsu_pkg::CH_N: begin
              lit_ev = 1'b1; lit_byte = jsu_pkg::LF_CODE;
            end
            jsu_pkg::CH_R: begin
              lit_ev = 1'b1; lit_byte = jsu_pkg::CR_CODE;
            end
            jsu_pkg::CH_T: begin
              lit_ev = 1'b1; lit_byte = jsu_pkg::TAB_CODE;
            end
            jsu_pkg::CH_U: begin
              start_hex = 1'b1;
              mode_nxt  = jsu_pkg::M_HEX1;
            end
            default: begin
              fail_err = jsu_pkg::ERR_ESCAPE;
              mode_nxt = jsu_pkg::M_DRAIN;
            end
          endcase
        end
        jsu_pkg::M_HEX1: begin
          if (!hv[4]) begin
            fail_err = jsu_pkg::ERR_ESCAPE;
            mode_nxt = jsu_pkg::M_DRAIN;
          end else begin
            digit_ev = 1'b1;
            if (hex_last) begin
              if (is_hi) begin
                set_hi   = 1'b1;
                mode_nxt = jsu_pkg::M_NEED_BS;
              end else if (is_lo) begin
                fail_err = jsu_pkg::ERR_ESCAPE;
                mode_nxt = jsu_pkg::M_DRAIN;
              end else begin
                cp_ev    = 1'b1;
                cp       = {5'd0, acc_new};
                mode_nxt = jsu_pkg::M_STR;
              end
            end
          end
        end
        jsu_pkg::M_NEED_BS: begin
          if (c == jsu_pkg::CH_BSLASH) begin
            mode_nxt = jsu_pkg::M_NEED_U;
          end else begin
            fail_err = jsu_pkg::ERR_ESCAPE;
            mode_nxt = jsu_pkg::M_DRAIN;
          end
        end
        jsu_pkg::M_NEED_U: begin
          if (c == jsu_pkg::CH_U) begin
            start_hex = 1'b1;
            mode_nxt  = jsu_pkg::M_HEX2;
          end else begin
            fail_err = jsu_pkg::ERR_ESCAPE;
            mode_nxt = jsu_pkg::M_DRAIN;
          end
        end
        jsu_pkg::M_HEX2: begin
          if (!hv[4]) begin
            fail_err = jsu_pkg::ERR_ESCAPE;
            mode_nxt = jsu_pkg::M_DRAIN;
          end else begin
            digit_ev = 1'b1;
            if (hex_last) begin
              if (is_lo) begin
                cp_ev    = 1'b1;
                cp       = jsu_pkg::SUPP_BASE + {1'b0, hi_bits_r, acc_new[9:0]};
                mode_nxt = jsu_pkg::M_STR;
              end else begin
                fail_err = jsu_pkg::ERR_ESCAPE;
                mode_nxt = jsu_pkg::M_DRAIN;
              end
            end
          end
        end
        default: mode_nxt = jsu_pkg::M_DRAIN;
      endcase
    end
  end

  assign enc = jsu_pkg::utf8_encode(cp);

  // job contents and datapath register updates
  always_comb begin
    emit_n = 3'd0;
    if (lit_ev) begin
      emit_n = 3'd1;
    end else if (cp_ev) begin
      emit_n = {1'b0, enc.nbytes_m1} + 3'd1;
    end
    sum = {1'b0, count_r} + (COUNT_WIDTH+1)'(emit_n);
    sat = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];

    // an error on the opening byte reports a cleared count
    rep_cnt  = clr_cnt ? '0 : count_r;
    rep_wide = {{jsu_pkg::LEN_W{1'b0}}, rep_cnt};

    if (clr_cnt || done_ev || (fail_err != jsu_pkg::ERR_NONE)) begin
      count_nxt = '0;
    end else begin
      count_nxt = sat;
    end

    hex_cnt_nxt = hex_cnt_r;
    hex_acc_nxt = hex_acc_r;
    if (start_hex) begin
      hex_cnt_nxt = 2'd0;
      hex_acc_nxt = 16'd0;
    end else if (digit_ev) begin
      hex_cnt_nxt = hex_cnt_r + 2'd1;
      hex_acc_nxt = acc_new;
    end
    hi_bits_nxt = set_hi ? acc_new[9:0] : hi_bits_r;

    job            = '0;
    job_push       = 1'b0;
    if (fail_err != jsu_pkg::ERR_NONE) begin
      job_push       = in_accept;
      job.kind       = jsu_pkg::KIND_ERR;
      job.error_code = fail_err;
      job.length     = rep_wide[jsu_pkg::LEN_W-1:0];
    end else if (done_ev) begin
      job_push   = in_accept;
      job.kind   = jsu_pkg::KIND_DONE;
      job.length = rep_wide[jsu_pkg::LEN_W-1:0];
    end else if (lit_ev) begin
      job_push      = in_accept;
      job.kind      = jsu_pkg::KIND_BYTE;
      job.bytes[0]  = lit_byte;
    end else if (cp_ev) begin
      job_push      = in_accept;
      job.kind      = jsu_pkg::KIND_BYTE;
      job.nbytes_m1 = enc.nbytes_m1;
      job.bytes     = enc.bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= jsu_pkg::M_IDLE;
      hex_cnt_r <= 2'd0;
      hex_acc_r <= 16'd0;
      hi_bits_r <= 10'd0;
      count_r   <= '0;
    end else if (in_accept) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      hex_acc_r <= hex_acc_nxt;
      hi_bits_r <= hi_bits_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// ----- rtl/jsu_job_fifo.sv -----
`timescale 1ns / 1ps
// Short job queue between the decode front end and the result back end.
// Depends on jsu_pkg.

module jsu_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output jsu_pkg::job_t head_job,
  output logic          empty
);

  jsu_pkg::job_t                   slots_r [jsu_pkg::JOB_DEPTH];
  logic [jsu_pkg::JOB_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [jsu_pkg::JOB_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [jsu_pkg::JOB_PTR_W:0]     fill_r, fill_nxt;
  logic                            do_push, do_pop;

  assign full     = (fill_r == (jsu_pkg::JOB_PTR_W+1)'(jsu_pkg::JOB_DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r + (jsu_pkg::JOB_PTR_W+1)'(do_push) - (jsu_pkg::JOB_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/jsu_back.sv -----
`timescale 1ns / 1ps
// Back end: expands each queued job into result requests, one per cycle into an output
// register while that register is empty or being popped. Depends on jsu_pkg.

module jsu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  jsu_pkg::job_t      job,
  input  logic               job_empty,
  output logic               job_pop,
  output jsu_pkg::out_item_t out_item,
  output logic               empty,
  input  logic               pop
);

  logic [1:0]         idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  jsu_pkg::out_item_t out_r, out_nxt;
  logic               advance, take, last_one;

  assign advance  = !out_valid_r || pop;
  assign take     = advance && !job_empty;
  assign last_one = (idx_r == job.nbytes_m1);
  assign job_pop  = take && last_one;

  always_comb begin
    out_nxt             = '0;
    out_nxt.result_kind = job.kind;
    out_nxt.last        = last_one;
    if (job.kind == jsu_pkg::KIND_BYTE) begin
      out_nxt.out_byte = job.bytes[idx_r];
    end else begin
      out_nxt.error_code     = job.error_code;
      out_nxt.decoded_length = job.length;
    end
    idx_nxt       = take ? (last_one ? 2'd0 : idx_r + 2'd1) : idx_r;
    out_valid_nxt = take ? 1'b1 : (pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;
  assign empty    = !out_valid_r;

endmodule

// ----- rtl/json_string_unescape.sv -----
`timescale 1ns / 1ps
// JSON string unescaper: top level tying front end, job queue and back end together.
// Depends on jsu_pkg, jsu_front, jsu_job_fifo, jsu_back.

// Feed the bytes of one JSON string literal, opening quote first, one byte per
// push request; an input_end request marks the end of the source. The block
// takes one input request every cycle while full is low: the front end decodes
// the byte combinationally and writes all results it causes (up to four
// UTF-8 bytes, or a completion or error report) as one job into a four-entry
// queue. The back end drains that queue one result request per cycle into an
// output register while that register is empty or being popped; full rises
// only when the result side falls behind by four jobs. Results appear in order
// with last marking the final result of each input item. After an error, bytes
// already delivered for that string are void and input is discarded until an
// input_end request. decoded_length saturates at 2^COUNT_WIDTH-1 and carries
// its low 20 bits. No clearing pass after reset.

module json_string_unescape #(
  parameter int COUNT_WIDTH = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  // input queue side
  input  logic               push,
  input  jsu_pkg::in_item_t  in_item,
  output logic               full,
  // result queue side
  output logic               empty,
  input  logic               pop,
  output jsu_pkg::out_item_t out_item
);

  logic          in_accept;
  logic          job_push, job_pop, job_empty;
  jsu_pkg::job_t job_in, job_head;

  // a request is taken whenever the job queue has room
  assign in_accept = push && !full;

  jsu_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_accept(in_accept),
    .in_item  (in_item),
    .job_push (job_push),
    .job      (job_in)
  );

  // decouples per-byte decode from multi-cycle result expansion
  jsu_job_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .push_job(job_in),
    .full    (full),
    .pop     (job_pop),
    .head_job(job_head),
    .empty   (job_empty)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (job_head),
    .job_empty(job_empty),
    .job_pop  (job_pop),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

// ----- test/json_string_unescape_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for json_string_unescape: directed rows, then random
// JSON string literals. Depends on jsu_pkg and the json_string_unescape RTL.

module json_string_unescape_tb;

  localparam int COUNT_W     = 20;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 300;

  // where the expectation of a stimulus row comes from
  typedef enum int {FROM_MODEL, TYPED_NONE, TYPED_ONE} check_kind_t;

  typedef struct {
    jsu_pkg::in_item_t  it;
    check_kind_t        chk;
    jsu_pkg::out_item_t res;
  } text_req_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  jsu_pkg::in_item_t  in_item = '0;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  jsu_pkg::out_item_t out_item;

  json_string_unescape #(.COUNT_WIDTH(COUNT_W)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Predictor state: a private copy of the decoder's mode and counters.
  // ------------------------------------------------------------------------
  jsu_pkg::mode_t     dec_mode = jsu_pkg::M_IDLE;
  logic [1:0]         hex_n    = '0;
  logic [15:0]        hex_acc  = '0;
  logic [9:0]         hi_bits  = '0;
  logic [COUNT_W-1:0] byte_cnt = '0;

  jsu_pkg::out_item_t step_res[$];    // results of the byte just decoded
  jsu_pkg::out_item_t decoded_q[$];   // results still owed by the block
  text_req_t text_q[$];               // JSON text waiting to be sent
  text_req_t directed_rows[28];

  int errors = 0;
  int queued_n = 0;
  int cycle_n = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_arm = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  function void add_result(logic [1:0] kind, logic [7:0] b, logic [1:0] err,
                           logic [COUNT_W-1:0] len);
    jsu_pkg::out_item_t r;
    r = '0;
    r.result_kind    = kind;
    r.out_byte       = b;
    r.error_code     = err;
    r.decoded_length = len[jsu_pkg::LEN_W-1:0];
    step_res.push_back(r);
  endfunction

  // decoded byte; the count sticks at all ones
  function void emit_byte(logic [7:0] b);
    if (byte_cnt != '1) byte_cnt = byte_cnt + 1'b1;
    add_result(jsu_pkg::KIND_BYTE, b, jsu_pkg::ERR_NONE, '0);
  endfunction

  // error report clears the count; an end item goes straight back to idle
  function void flag_error(logic [1:0] err, bit at_end);
    add_result(jsu_pkg::KIND_ERR, 8'h00, err, byte_cnt);
    byte_cnt = '0;
    dec_mode = at_end ? jsu_pkg::M_IDLE : jsu_pkg::M_DRAIN;
  endfunction

  function int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // 1: four digits complete, 0: more needed, -1: not a hex digit
  function int next_hex(logic [7:0] c);
    int d;
    d = hex_nibble(c);
    if (d < 0) return -1;
    hex_acc = {hex_acc[11:0], 4'(d)};
    if (hex_n == 2'd3) begin
      hex_n = '0;
      return 1;
    end
    hex_n = hex_n + 1'b1;
    return 0;
  endfunction

  function void emit_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      emit_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      emit_byte(8'hC0 | 8'(cp >> 6));
      emit_byte(8'h80 | 8'(cp & 21'h3F));
    end else if (cp < 21'h10000) begin
      emit_byte(8'hE0 | 8'(cp >> 12));
      emit_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
      emit_byte(8'h80 | 8'(cp & 21'h3F));
    end else begin
      emit_byte(8'hF0 | 8'(cp >> 18));
      emit_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
      emit_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
      emit_byte(8'h80 | 8'(cp & 21'h3F));
    end
  endfunction

  // One input request through the decoder; fills step_res.
  function void unescape_byte(jsu_pkg::in_item_t it);
    logic [7:0]         c;
    int                 h;
    logic [20:0]        cp;
    jsu_pkg::out_item_t t;
    step_res.delete();
    c = it.data_byte;
    if (it.input_end) begin
      case (dec_mode)
        jsu_pkg::M_STR, jsu_pkg::M_ESC:
          flag_error(jsu_pkg::ERR_UNTERM, 1'b1);
        jsu_pkg::M_HEX1, jsu_pkg::M_NEED_BS, jsu_pkg::M_NEED_U, jsu_pkg::M_HEX2:
          flag_error(jsu_pkg::ERR_ESCAPE, 1'b1);
        default: begin
          dec_mode = jsu_pkg::M_IDLE;
          byte_cnt = '0;
        end
      endcase
    end else begin
      case (dec_mode)
        jsu_pkg::M_IDLE: begin
          byte_cnt = '0;
          if (c == jsu_pkg::CH_QUOTE) dec_mode = jsu_pkg::M_STR;
          else flag_error(jsu_pkg::ERR_SYNTAX, 1'b0);
        end
        jsu_pkg::M_STR: begin
          if (c == jsu_pkg::CH_QUOTE) begin
            add_result(jsu_pkg::KIND_DONE, 8'h00, jsu_pkg::ERR_NONE, byte_cnt);
            byte_cnt = '0;
            dec_mode = jsu_pkg::M_IDLE;
          end else if (c == jsu_pkg::CH_BSLASH) begin
            dec_mode = jsu_pkg::M_ESC;
          end else if (c < jsu_pkg::CTRL_LIM) begin
            flag_error(jsu_pkg::ERR_SYNTAX, 1'b0);
          end else begin
            emit_byte(c);
          end
        end
        jsu_pkg::M_ESC: begin
          dec_mode = jsu_pkg::M_STR;
          case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: emit_byte(c);
            jsu_pkg::CH_B: emit_byte(jsu_pkg::BS_CODE);
            jsu_pkg::CH_F: emit_byte(jsu_pkg::FF_CODE);
            jsu_pkg::CH_N: emit_byte(jsu_pkg::LF_CODE);
            jsu_pkg::CH_R: emit_byte(jsu_pkg::CR_CODE);
            jsu_pkg::CH_T: emit_byte(jsu_pkg::TAB_CODE);
            jsu_pkg::CH_U: begin
              hex_n    = '0;
              hex_acc  = '0;
              dec_mode = jsu_pkg::M_HEX1;
            end
            default: flag_error(jsu_pkg::ERR_ESCAPE, 1'b0);
          endcase
        end
        jsu_pkg::M_HEX1: begin
          h = next_hex(c);
          if (h < 0) begin
            flag_error(jsu_pkg::ERR_ESCAPE, 1'b0);
          end else if (h > 0) begin
            if (hex_acc >= jsu_pkg::HI_SURR_MIN && hex_acc <= jsu_pkg::HI_SURR_MAX) begin
              hi_bits  = 10'(hex_acc - jsu_pkg::HI_SURR_MIN);
              dec_mode = jsu_pkg::M_NEED_BS;
            end else if (hex_acc >= jsu_pkg::LO_SURR_MIN &&
                         hex_acc <= jsu_pkg::LO_SURR_MAX) begin
              flag_error(jsu_pkg::ERR_ESCAPE, 1'b0);
            end else begin
              emit_code_point(21'(hex_acc));
              dec_mode = jsu_pkg::M_STR;
            end
          end
        end
        jsu_pkg::M_NEED_BS: begin
          if (c == jsu_pkg::CH_BSLASH) dec_mode = jsu_pkg::M_NEED_U;
          else flag_error(jsu_pkg::ERR_ESCAPE, 1'b0);
        end
        jsu_pkg::M_NEED_U: begin
          if (c == jsu_pkg::CH_U) begin
            hex_n    = '0;
            hex_acc  = '0;
            dec_mode = jsu_pkg::M_HEX2;
          end else begin
            flag_error(jsu_pkg::ERR_ESCAPE, 1'b0);
          end
        end
        jsu_pkg::M_HEX2: begin
          h = next_hex(c);
          if (h < 0) begin
            flag_error(jsu_pkg::ERR_ESCAPE, 1'b0);
          end else if (h > 0) begin
            if (hex_acc >= jsu_pkg::LO_SURR_MIN && hex_acc <= jsu_pkg::LO_SURR_MAX) begin
              cp = jsu_pkg::SUPP_BASE + 21'({hi_bits, 10'd0}) +
                   21'(hex_acc - jsu_pkg::LO_SURR_MIN);
              emit_code_point(cp);
              dec_mode = jsu_pkg::M_STR;
            end else begin
              flag_error(jsu_pkg::ERR_ESCAPE, 1'b0);
            end
          end
        end
        default: dec_mode = jsu_pkg::M_DRAIN;
      endcase
    end
    if (step_res.size() > 0) begin
      t = step_res[step_res.size()-1];
      t.last = 1'b1;
      step_res[step_res.size()-1] = t;
    end
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus building
  // ------------------------------------------------------------------------
  function text_req_t text_row(logic [7:0] b, bit e, check_kind_t chk,
                               logic [1:0] kind, logic [7:0] ob, logic [1:0] err,
                               logic [jsu_pkg::LEN_W-1:0] len);
    text_req_t r;
    r.it.data_byte          = b;
    r.it.input_end          = e;
    r.chk                   = chk;
    r.res                   = '0;
    r.res.result_kind       = kind;
    r.res.out_byte          = ob;
    r.res.error_code        = err;
    r.res.decoded_length    = len;
    r.res.last              = 1'b1;
    return r;
  endfunction

  function void put_text(logic [7:0] b, bit e);
    text_q.push_back(text_row(b, e, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00,
                              jsu_pkg::ERR_NONE, '0));
    queued_n++;
  endfunction

  function logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function logic [7:0] non_hex_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (hex_nibble(b) >= 0);
    return b;
  endfunction

  // \uXXXX with random letter case
  function void put_u(logic [15:0] v);
    put_text(jsu_pkg::CH_BSLASH, 1'b0);
    put_text(jsu_pkg::CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) put_text(hex_char(v[i*4 +: 4]), 1'b0);
  endfunction

  function void put_hex_digits(int k);
    for (int i = 0; i < k; i++) put_text(hex_char(4'($urandom_range(15))), 1'b0);
  endfunction

  // a code point that is no surrogate, spread over the one- to three-byte UTF-8 lengths
  function logic [15:0] rand_bmp();
    logic [15:0] v;
    logic [15:0] edges[8];
    edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF,
              16'hE000, 16'hFFFF};
    case ($urandom_range(3))
      0: v = 16'($urandom_range(16'h7F));
      1: v = 16'($urandom_range(16'h80, 16'h7FF));
      2: do v = 16'($urandom_range(16'h800, 16'hFFFF));
         while (v >= jsu_pkg::HI_SURR_MIN && v <= jsu_pkg::LO_SURR_MAX);
      default: v = edges[$urandom_range(7)];
    endcase
    return v;
  endfunction

  function logic [15:0] rand_high();
    if ($urandom_range(3) == 0) begin
      return $urandom_range(1) ? jsu_pkg::HI_SURR_MAX : jsu_pkg::HI_SURR_MIN;
    end
    return 16'($urandom_range(jsu_pkg::HI_SURR_MIN, jsu_pkg::HI_SURR_MAX));
  endfunction

  function logic [15:0] rand_low();
    if ($urandom_range(3) == 0) begin
      return $urandom_range(1) ? jsu_pkg::LO_SURR_MAX : jsu_pkg::LO_SURR_MIN;
    end
    return 16'($urandom_range(jsu_pkg::LO_SURR_MIN, jsu_pkg::LO_SURR_MAX));
  endfunction

  // junk the block must swallow after an error, closed by an end request
  function void put_discard_tail();
    int k;
    k = $urandom_range(3);
    for (int i = 0; i < k; i++) put_text(8'($urandom_range(255)), 1'b0);
    put_text(8'($urandom_range(255)), 1'b1);
  endfunction

  // One string literal: mostly well formed, now and then broken on purpose.
  function void gen_string();
    int          ntok;
    int          fault;
    logic [7:0]  b;
    logic [15:0] v;
    logic [7:0]  simple_esc[8];
    simple_esc = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
                   jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T};
    // garbage where the opening quote should be
    if ($urandom_range(11) == 0) begin
      do b = 8'($urandom_range(255)); while (b == jsu_pkg::CH_QUOTE);
      put_text(b, 1'b0);
      put_discard_tail();
      return;
    end
    put_text(jsu_pkg::CH_QUOTE, 1'b0);
    ntok = $urandom_range(8);
    for (int i = 0; i < ntok; i++) begin
      case ($urandom_range(7))
        4: begin
          put_text(jsu_pkg::CH_BSLASH, 1'b0);
          put_text(simple_esc[$urandom_range(7)], 1'b0);
        end
        5, 6: put_u(rand_bmp());
        7: begin
          put_u(rand_high());
          put_u(rand_low());
        end
        default: begin
          // printable ASCII and high bytes pass straight through
          do b = 8'($urandom_range(8'h20, 8'hFF));
          while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
          put_text(b, 1'b0);
        end
      endcase
    end
    fault = ($urandom_range(99) < 30) ? $urandom_range(1, 10) : 0;
    case (fault)
      0: begin
        put_text(jsu_pkg::CH_QUOTE, 1'b0);
        if ($urandom_range(3) == 0) put_text(8'($urandom_range(255)), 1'b1);
      end
      1: begin                              // raw control byte
        put_text(8'($urandom_range(8'h1F)), 1'b0);
        put_discard_tail();
      end
      2: begin                              // unknown escape letter
        put_text(jsu_pkg::CH_BSLASH, 1'b0);
        do b = 8'($urandom_range(255));
        while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH ||
               b == jsu_pkg::CH_SLASH || b == jsu_pkg::CH_B || b == jsu_pkg::CH_F ||
               b == jsu_pkg::CH_N || b == jsu_pkg::CH_R || b == jsu_pkg::CH_T ||
               b == jsu_pkg::CH_U);
        put_text(b, 1'b0);
        put_discard_tail();
      end
      3: begin                              // bad digit inside \u
        put_text(jsu_pkg::CH_BSLASH, 1'b0);
        put_text(jsu_pkg::CH_U, 1'b0);
        put_hex_digits($urandom_range(3));
        put_text(non_hex_byte(), 1'b0);
        put_discard_tail();
      end
      4: begin                              // low surrogate on its own
        put_u(rand_low());
        put_discard_tail();
      end
      5: begin                              // high surrogate, no backslash after
        put_u(rand_high());
        do b = 8'($urandom_range(255)); while (b == jsu_pkg::CH_BSLASH);
        put_text(b, 1'b0);
        put_discard_tail();
      end
      6: begin                              // high surrogate, backslash, no u
        put_u(rand_high());
        put_text(jsu_pkg::CH_BSLASH, 1'b0);
        do b = 8'($urandom_range(255)); while (b == jsu_pkg::CH_U);
        put_text(b, 1'b0);
        put_discard_tail();
      end
      7: begin                              // high surrogate, then no low one
        put_u(rand_high());
        v = $urandom_range(1) ? 16'($urandom_range(16'hDBFF))
                              : 16'($urandom_range(16'hE000, 16'hFFFF));
        put_u(v);
        put_discard_tail();
      end
      8: put_text(8'($urandom_range(255)), 1'b1);   // source ends mid string
      9: begin                              // source ends right after backslash
        put_text(jsu_pkg::CH_BSLASH, 1'b0);
        put_text(8'($urandom_range(255)), 1'b1);
      end
      default: begin                        // source ends inside a \u escape
        case ($urandom_range(2))
          0: begin
            put_text(jsu_pkg::CH_BSLASH, 1'b0);
            put_text(jsu_pkg::CH_U, 1'b0);
            put_hex_digits($urandom_range(3));
          end
          1: put_u(rand_high());
          default: begin
            put_u(rand_high());
            put_text(jsu_pkg::CH_BSLASH, 1'b0);
            if ($urandom_range(1)) begin
              put_text(jsu_pkg::CH_U, 1'b0);
              put_hex_digits($urandom_range(3));
            end
          end
        endcase
        put_text(8'($urandom_range(255)), 1'b1);
      end
    endcase
  endfunction

  task automatic gen_strings(int n);
    int start;
    start = queued_n;
    while (queued_n - start < n) gen_string();
  endtask

  // hold the sender back until the block has delivered everything owed
  task automatic drain_all();
    while (text_q.size() > 0 || push) @(posedge clk);
    while (decoded_q.size() > 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // Sender: offers the head of text_q; a stalled request is held unchanged.
  // The predictor runs on each accepted request.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      push    <= 1'b0;
      in_item <= '0;
    end else begin
      if (push && !full) begin
        unescape_byte(in_item);
        case (text_q[0].chk)
          TYPED_ONE:  decoded_q.push_back(text_q[0].res);
          TYPED_NONE: ;
          default:    foreach (step_res[i]) decoded_q.push_back(step_res[i]);
        endcase
        void'(text_q.pop_front());
      end
      if (push && full) begin
        // request still pending; keep it on the port
      end else if (text_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push    <= 1'b1;
        in_item <= text_q[0].it;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Receiver: checks each popped result against the oldest expectation.
  // A long hold, counted here, lets the block fill and push back on input.
  // ------------------------------------------------------------------------
  task automatic cmp_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    jsu_pkg::out_item_t exp_r;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d byte 0x%0h",
                   $time, out_item.result_kind, out_item.out_byte);
          errors++;
        end else begin
          exp_r = decoded_q.pop_front();
          cmp_field("result_kind", exp_r.result_kind, out_item.result_kind);
          cmp_field("out_byte", exp_r.out_byte, out_item.out_byte);
          cmp_field("error_code", exp_r.error_code, out_item.error_code);
          cmp_field("decoded_length", exp_r.decoded_length, out_item.decoded_length);
          cmp_field("last", exp_r.last, out_item.last);
        end
      end
      if (hold_arm && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    // Directed rows. Typed expectations are the obvious ones; the rest go
    // through the predictor. Running length of the first string: 0xFF, space,
    // tab, U+FFFF (3 bytes), U+00E9 (2 bytes) = 8.
    directed_rows = '{
      // no quote
      text_row(8'h00, 1'b0, TYPED_ONE, jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_SYNTAX, 20'd0),
      // end, discard
      text_row(8'hFF, 1'b1, TYPED_NONE, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      // end, idle
      text_row(8'h00, 1'b1, TYPED_NONE, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h22, 1'b0, TYPED_NONE, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      // high byte
      text_row(8'hFF, 1'b0, TYPED_ONE, jsu_pkg::KIND_BYTE, 8'hFF, jsu_pkg::ERR_NONE, 20'd0),
      // lowest plain
      text_row(8'h20, 1'b0, TYPED_ONE, jsu_pkg::KIND_BYTE, 8'h20, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h5C, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      // \t
      text_row(8'h74, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h5C, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      // \uFffF
      text_row(8'h75, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h46, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h66, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h66, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h46, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h5C, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      // \u00e9
      text_row(8'h75, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h30, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h30, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h65, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h39, 1'b0, FROM_MODEL, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      // close
      text_row(8'h22, 1'b0, TYPED_ONE, jsu_pkg::KIND_DONE, 8'h00, jsu_pkg::ERR_NONE, 20'd8),
      text_row(8'h22, 1'b0, TYPED_NONE, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      // control
      text_row(8'h1F, 1'b0, TYPED_ONE, jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_SYNTAX, 20'd0),
      // discarded
      text_row(8'h7F, 1'b0, TYPED_NONE, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h00, 1'b1, TYPED_NONE, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h22, 1'b0, TYPED_NONE, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      text_row(8'h5C, 1'b0, TYPED_NONE, jsu_pkg::KIND_BYTE, 8'h00, jsu_pkg::ERR_NONE, 20'd0),
      // end in escape
      text_row(8'h00, 1'b1, TYPED_ONE, jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_UNTERM, 20'd0)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // no idling on either side
    foreach (directed_rows[i]) text_q.push_back(directed_rows[i]);
    gen_strings(100);
    drain_all();

    // sender mostly idle
    send_idle_pct = 76;
    gen_strings(100);
    drain_all();

    // receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct = 76;
    gen_strings(100);
    drain_all();

    // light idling on both sides
    send_idle_pct  = 6;
    recv_stall_pct = 6;
    gen_strings(100);
    drain_all();

    // back-pressure: result side frozen while requests keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_arm       = 1'b1;
    gen_strings(80);
    drain_all();

    // let any stray result show up
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
